[rtl/srr_pkg.sv]
// Shared types and constants for the selective-repeat receiver.
// Beat structs, slot cell struct, result kind codes and fixed limits.
// No dependencies.
package srr_pkg;

    // Input beat: one checksum-valid packet
    typedef struct packed {
        logic [31:0] seq_num;
        logic [10:0] payload_len;
        logic [63:0] payload_word;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_seq;
        logic [10:0] out_len;
        logic [63:0] out_word;
        logic        last;
    } out_beat_t;

    // One receive slot held by a cell
    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [10:0] len;
        logic [63:0] word;
    } slot_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic rotate;
        logic write;
        logic clear;
    } cell_ctrl_t;

    // Result kinds
    localparam logic [1:0] KindAck     = 2'd0;
    localparam logic [1:0] KindDeliver = 2'd1;
    localparam logic [1:0] KindEos     = 2'd2;

    // Register index of initial_seq (paddr[2])
    localparam logic RegInitialSeq = 1'b0;

    // Limits
    localparam logic [16:0] MaxPayload = 17'd1024;
    localparam logic [31:0] SeqMax     = 32'hFFFF_FFFF;

endpackage

[rtl/srr_cell.sv]
// One receive slot of the rotating slot ring, emptied on clear.
// Takes its neighbor's slot on rotate, else a new packet on write.
// Depends on srr_pkg.
module srr_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  srr_pkg::cell_ctrl_t ctrl,
    input  srr_pkg::slot_t      shift_in,
    input  srr_pkg::slot_t      wr_data,
    output srr_pkg::slot_t      slot_out
);

    logic        valid_reg, valid_next;
    logic [31:0] seq_reg, seq_next;
    logic [10:0] len_reg, len_next;
    logic [63:0] word_reg, word_next;

    // rotate wins, then write, then clear
    always_comb begin
        valid_next = valid_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        word_next  = word_reg;
        if (ctrl.rotate) begin
            valid_next = shift_in.valid;
            seq_next   = shift_in.seq;
            len_next   = shift_in.len;
            word_next  = shift_in.word;
        end else if (ctrl.write) begin
            valid_next = wr_data.valid;
            seq_next   = wr_data.seq;
            len_next   = wr_data.len;
            word_next  = wr_data.word;
        end else if (ctrl.clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg  <= seq_next;
        len_reg  <= len_next;
        word_reg <= word_next;
    end

    assign slot_out = '{valid: valid_reg, seq: seq_reg, len: len_reg, word: word_reg};

endmodule

[rtl/srr_mod_unit.sv]
// Remainder unit: value mod WINDOW by reciprocal multiply, two register stages.
// Result valid when busy falls after start; busy stays high meanwhile.
// No package dependency.
module srr_mod_unit #(
    parameter int WINDOW = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 value,
    output logic                        busy,
    output logic [$clog2(WINDOW)-1:0]   result
);

    localparam int IdxW = $clog2(WINDOW);
    localparam int Shift = 32 + IdxW;
    // ceil(2^Shift / WINDOW): exact quotient for every 32-bit value
    localparam logic [32:0] Recip =
        33'(((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [31:0] Divisor = 32'(WINDOW);

    logic [31:0]     val_reg, val_next;
    logic [31:0]     quo_reg, quo_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [IdxW-1:0] rem_reg, rem_next;
    logic [64:0]     prod;
    logic [31:0]     rem_full;

    // stage 2: quotient from the reciprocal; stage 1: value minus quotient times W
    always_comb begin
        prod     = {33'd0, val_reg} * {32'd0, Recip};
        rem_full = val_reg - quo_reg * Divisor;
        val_next = val_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        if (start) begin
            val_next = value;
            cnt_next = 2'd2;
        end else if (cnt_reg == 2'd2) begin
            quo_next = 32'(prod >> Shift);
            cnt_next = 2'd1;
        end else if (cnt_reg == 2'd1) begin
            rem_next = rem_full[IdxW-1:0];
            cnt_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rem_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        quo_reg <= quo_next;
    end

    assign busy   = (cnt_reg != 2'd0);
    assign result = rem_reg;

endmodule

[rtl/selective_repeat_receiver.sv]
// Selective-repeat ARQ receiver: s_ packet channel in, m_ result channel out.
// Input beat: seq_num, payload_len, payload_word. Every packet on an open
// stream gets an acknowledge beat; an in-window packet at the base is
// delivered, then buffered packets continuing the run; other in-window
// packets are buffered; an empty in-window payload closes the stream.
// The acknowledge beat is registered and valid the cycle after accept. An item
// yields 1 to WINDOW+1 result beats through the single output register, which
// takes one beat per cycle while m_ready allows; the drain walks a ring of
// WINDOW slot cells that rotates once per delivery below SeqMax.
// A packet is accepted only in idle; one on a closed stream gives no result.
// If m_ready is low while a result beat is held, the sequencer holds and s_ready stays low.
// APB: initial_seq at byte 0, writes load the base. After a write the block
// computes initial_seq mod WINDOW and rotates the ring into place; s_ready
// stays low while the remainder is computed and through each rotation (up to WINDOW-1).
// Reset (aresetn low, synchronous): base 0, stream open, all slots empty.
// Depends on srr_pkg, srr_cell, srr_mod_unit.
module selective_repeat_receiver #(
    parameter int WINDOW = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srr_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output srr_pkg::out_beat_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IdxW = $clog2(WINDOW);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);

    // sequencer states
    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StEos     = 3'd1;
    localparam logic [2:0] StDeliver = 3'd2;
    localparam logic [2:0] StDrain   = 3'd3;
    localparam logic [2:0] StMod     = 3'd4;
    localparam logic [2:0] StAlign   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [31:0]        base_reg, base_next;
    logic [IdxW-1:0]    base_mod_reg, base_mod_next;
    logic [IdxW-1:0]    drain_cnt_reg, drain_cnt_next;
    logic [31:0]        init_reg, init_next;
    logic               closed_reg, closed_next;
    logic [31:0]        cur_seq_reg, cur_seq_next;
    logic [10:0]        cur_len_reg, cur_len_next;
    logic [63:0]        cur_word_reg, cur_word_next;
    srr_pkg::out_beat_t out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic               cfg_hit;
    logic               out_free;
    logic               in_acc;
    logic [32:0]        diff;
    logic               in_win;
    logic [IdxW-1:0]    offset;
    logic [10:0]        sat_len;
    logic               len_zero;
    logic               is_eos;
    logic               is_del;
    logic               is_store;
    logic               advance;
    logic               more;
    logic               rotate_go;
    logic               clear0;
    logic               store_go;
    logic               mod_busy;
    logic [IdxW-1:0]    mod_result;
    logic [IdxW-1:0]    base_mod_inc;

    srr_pkg::slot_t     cell_q   [WINDOW];
    srr_pkg::slot_t     shift_in [WINDOW];
    srr_pkg::cell_ctrl_t cell_ctrl [WINDOW];
    srr_pkg::slot_t     wr_slot;

    // APB: always ready, single register
    assign pready  = 1'b1;
    assign cfg_hit = psel && penable && pwrite && (paddr[2] == srr_pkg::RegInitialSeq);
    assign prdata  = (paddr[2] == srr_pkg::RegInitialSeq) ? init_reg : 32'd0;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == StIdle) && out_free;
    assign in_acc   = s_valid && s_ready;

    // window test, clipped at the top of the sequence space
    assign diff     = {1'b0, s_data.seq_num} - {1'b0, base_reg};
    assign in_win   = !diff[32] && (diff[31:0] < 32'(WINDOW));
    assign offset   = diff[IdxW-1:0];
    assign len_zero = (s_data.payload_len == 11'd0);
    assign sat_len  = ({6'd0, s_data.payload_len} > srr_pkg::MaxPayload)
                      ? srr_pkg::MaxPayload[10:0] : s_data.payload_len;
    assign is_eos   = in_win && len_zero;
    assign is_del   = in_win && !len_zero && (diff[31:0] == 32'd0);
    assign is_store = in_win && !len_zero && !is_del;

    // drain lookahead: next cell continues the run, at most WINDOW-1 drains
    assign advance  = (base_reg != srr_pkg::SeqMax);
    assign more     = advance && (drain_cnt_reg != LastIdx) && cell_q[1].valid &&
                      (cell_q[1].seq == base_reg + 32'd1);
    assign base_mod_inc = (base_mod_reg == LastIdx) ? '0 : base_mod_reg + 1'b1;

    assign wr_slot = '{valid: 1'b1, seq: s_data.seq_num, len: sat_len,
                       word: s_data.payload_word};

    // sequencer
    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        base_mod_next  = base_mod_reg;
        drain_cnt_next = drain_cnt_reg;
        init_next      = init_reg;
        closed_next    = closed_reg;
        cur_seq_next   = cur_seq_reg;
        cur_len_next   = cur_len_reg;
        cur_word_next  = cur_word_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        rotate_go      = 1'b0;
        clear0         = 1'b0;
        store_go       = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            StIdle: begin
                if (in_acc && !closed_reg) begin
                    out_next = '{kind: srr_pkg::KindAck, out_seq: s_data.seq_num,
                                 out_len: 11'd0, out_word: 64'd0,
                                 last: !(is_eos || is_del)};
                    m_valid_next   = 1'b1;
                    cur_seq_next   = s_data.seq_num;
                    cur_len_next   = sat_len;
                    cur_word_next  = s_data.payload_word;
                    drain_cnt_next = '0;
                    store_go       = is_store;
                    if (is_eos) begin
                        closed_next = 1'b1;
                        state_next  = StEos;
                    end else if (is_del) begin
                        state_next = StDeliver;
                    end
                end
            end
            StEos: begin
                if (out_free) begin
                    out_next = '{kind: srr_pkg::KindEos, out_seq: cur_seq_reg,
                                 out_len: 11'd0, out_word: 64'd0, last: 1'b1};
                    m_valid_next = 1'b1;
                    state_next   = StIdle;
                end
            end
            StDeliver: begin
                if (out_free) begin
                    out_next = '{kind: srr_pkg::KindDeliver, out_seq: cur_seq_reg,
                                 out_len: cur_len_reg, out_word: cur_word_reg,
                                 last: !more};
                    m_valid_next = 1'b1;
                    rotate_go    = advance;
                    if (advance) begin
                        base_next = base_reg + 32'd1;
                    end
                    if (more) begin
                        drain_cnt_next = drain_cnt_reg + 1'b1;
                    end
                    state_next = more ? StDrain : StIdle;
                end
            end
            StDrain: begin
                if (out_free) begin
                    out_next = '{kind: srr_pkg::KindDeliver, out_seq: cell_q[0].seq,
                                 out_len: cell_q[0].len, out_word: cell_q[0].word,
                                 last: !more};
                    m_valid_next = 1'b1;
                    clear0       = 1'b1;
                    rotate_go    = advance;
                    if (advance) begin
                        base_next = base_reg + 32'd1;
                    end
                    if (more) begin
                        drain_cnt_next = drain_cnt_reg + 1'b1;
                    end
                    state_next = more ? StDrain : StIdle;
                end
            end
            StMod: begin
                if (!mod_busy) begin
                    state_next = StAlign;
                end
            end
            StAlign: begin
                if (base_mod_reg == mod_result) begin
                    state_next = StIdle;
                end else begin
                    rotate_go = 1'b1;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase

        // ring residue follows every rotation
        if (rotate_go) begin
            base_mod_next = base_mod_inc;
        end

        // register write loads the base and realigns the ring
        if (cfg_hit) begin
            init_next  = pwdata;
            base_next  = pwdata;
            state_next = StMod;
        end
    end

    // slot ring
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        if (k == WINDOW - 1) begin : g_wrap
            // head slot wraps to the tail, emptied if just drained
            always_comb begin
                shift_in[k]       = cell_q[0];
                shift_in[k].valid = cell_q[0].valid && !clear0;
            end
        end else begin : g_link
            assign shift_in[k] = cell_q[k+1];
        end

        always_comb begin
            cell_ctrl[k].rotate = rotate_go;
            cell_ctrl[k].write  = store_go && (offset == IdxW'(k)) &&
                                  !(cell_q[k].valid && (cell_q[k].seq == s_data.seq_num));
            cell_ctrl[k].clear  = (k == 0) ? clear0 : 1'b0;
        end

        srr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl[k]),
            .shift_in (shift_in[k]),
            .wr_data  (wr_slot),
            .slot_out (cell_q[k])
        );
    end

    srr_mod_unit #(
        .WINDOW (WINDOW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_hit),
        .value   (pwdata),
        .busy    (mod_busy),
        .result  (mod_result)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= StIdle;
            base_reg      <= 32'd0;
            base_mod_reg  <= '0;
            drain_cnt_reg <= '0;
            init_reg      <= 32'd0;
            closed_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            base_mod_reg  <= base_mod_next;
            drain_cnt_reg <= drain_cnt_next;
            init_reg      <= init_next;
            closed_reg    <= closed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_seq_reg  <= cur_seq_next;
        cur_len_reg  <= cur_len_next;
        cur_word_reg <= cur_word_next;
        out_reg      <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // a drain beat always comes from a head slot that continues the run
    a_drain_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == StDrain) |-> (cell_q[0].valid && (cell_q[0].seq == base_reg)))
        else $error("drain state without a matching head slot");

    // a closed stream stays closed until reset
    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |=> closed_reg)
        else $error("stream reopened without reset");

    // the base only moves back through a register write
    a_base_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_hit |=> (base_reg >= $past(base_reg)))
        else $error("base decreased without a register write");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for selective_repeat_receiver: packet beats in, result beats out.
// An in-bench receiver model predicts every result beat; APB writes set initial_seq.
// Depends on srr_pkg and the selective_repeat_receiver RTL.
module testbench;

    localparam int WIN = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 24;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] AddrInitialSeq = {srr_pkg::RegInitialSeq, 2'b00};

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    srr_pkg::in_beat_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    srr_pkg::out_beat_t  m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    selective_repeat_receiver #(.WINDOW(WIN)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    // Receiver model state
    logic [31:0] rx_base = '0;
    logic        rx_closed = 1'b0;
    logic        buf_vld [WIN] = '{default: 1'b0};
    logic [31:0] buf_seq [WIN];
    logic [10:0] buf_len [WIN];
    logic [63:0] buf_word [WIN];

    srr_pkg::out_beat_t rx_pending [$];   // result beats still owed by the block
    srr_pkg::in_beat_t  pkt_q [$];        // packets waiting for the driver
    int          err_cnt = 0;
    int          src_idle_pct = 25;
    int          sink_idle_pct = 25;
    logic        hold_req = 1'b0;
    logic [32:0] gen_base = '0;    // stimulus view of the receive base

    function automatic srr_pkg::out_beat_t mk_beat(logic [1:0] kind, logic [31:0] seq,
                                                   logic [10:0] len, logic [63:0] word);
        srr_pkg::out_beat_t b;
        b.kind = kind;
        b.out_seq = seq;
        b.out_len = len;
        b.out_word = word;
        b.last = 1'b0;
        return b;
    endfunction

    // Work out the result beats of one accepted packet and update the model
    function automatic void rx_model_packet(srr_pkg::in_beat_t pkt);
        srr_pkg::out_beat_t beats [$];
        srr_pkg::out_beat_t tail;
        logic [32:0] lo;
        logic [32:0] seq33;
        logic [10:0] len;
        int          slot;
        int          run;
        bit          moved;
        if (rx_closed) return;
        beats.push_back(mk_beat(srr_pkg::KindAck, pkt.seq_num, '0, '0));
        lo = {1'b0, rx_base};
        seq33 = {1'b0, pkt.seq_num};
        if (seq33 >= lo && seq33 < lo + 33'(WIN)) begin
            len = (pkt.payload_len > srr_pkg::MaxPayload) ? srr_pkg::MaxPayload[10:0]
                                                          : pkt.payload_len;
            if (len == 0) begin
                rx_closed = 1'b1;
                beats.push_back(mk_beat(srr_pkg::KindEos, pkt.seq_num, '0, '0));
            end else if (pkt.seq_num == rx_base) begin
                beats.push_back(mk_beat(srr_pkg::KindDeliver, pkt.seq_num, len,
                                        pkt.payload_word));
                moved = rx_base != srr_pkg::SeqMax;
                if (moved) rx_base = rx_base + 1;
                run = 0;
                // drain buffered packets that continue the run
                while (moved && run < WIN - 1) begin
                    slot = int'(rx_base % 32'(WIN));
                    if (!buf_vld[slot] || buf_seq[slot] != rx_base) break;
                    beats.push_back(mk_beat(srr_pkg::KindDeliver, buf_seq[slot],
                                            buf_len[slot], buf_word[slot]));
                    buf_vld[slot] = 1'b0;
                    run++;
                    moved = rx_base != srr_pkg::SeqMax;
                    if (moved) rx_base = rx_base + 1;
                end
            end else begin
                slot = int'(pkt.seq_num % 32'(WIN));
                // a duplicate keeps the first copy
                if (!(buf_vld[slot] && buf_seq[slot] == pkt.seq_num)) begin
                    buf_vld[slot] = 1'b1;
                    buf_seq[slot] = pkt.seq_num;
                    buf_len[slot] = len;
                    buf_word[slot] = pkt.payload_word;
                end
            end
        end
        tail = beats.pop_back();
        tail.last = 1'b1;
        beats.push_back(tail);
        foreach (beats[i]) rx_pending.push_back(beats[i]);
    endfunction

    function automatic void check_beat(srr_pkg::out_beat_t got);
        srr_pkg::out_beat_t want;
        if (rx_pending.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("ERROR: result beat with none expected: kind %0d seq %h len %0d",
                         got.kind, got.out_seq, got.out_len);
            return;
        end
        want = rx_pending.pop_front();
        if (got.kind !== want.kind || got.out_seq !== want.out_seq ||
            got.out_len !== want.out_len || got.out_word !== want.out_word ||
            got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display({"ERROR: result mismatch (expected/actual): kind %0d/%0d ",
                          "seq %h/%h len %0d/%0d word %h/%h last %0d/%0d"},
                         want.kind, got.kind, want.out_seq, got.out_seq,
                         want.out_len, got.out_len, want.out_word, got.out_word,
                         want.last, got.last);
        end
    endfunction

    // Packet driver: model runs on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) rx_model_packet(s_data);
            if (!s_valid || s_ready) begin
                if (pkt_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_data <= pkt_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls and a long hold-off on request
    int   hold_left = 0;
    logic hold_seen = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_beat(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog
    int cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Nonzero length, with some at and above the payload limit
    function automatic logic [10:0] rand_len();
        case ($urandom_range(0, 9))
            0:       return 11'd1;
            1:       return 11'd1024;
            2:       return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(1, 1023));
        endcase
    endfunction

    function automatic void add_pkt(logic [31:0] seq, logic [10:0] len, logic [63:0] word);
        srr_pkg::in_beat_t p;
        p.seq_num = seq;
        p.payload_len = len;
        p.payload_word = word;
        pkt_q.push_back(p);
    endfunction

    // Out-of-window packet; an empty payload is kept away from any possible window
    function automatic void add_noise(logic [32:0] lo_base);
        logic [32:0] s;
        logic [10:0] len;
        case ($urandom_range(0, 2))
            0:       s = lo_base - 33'd1 - 33'($urandom_range(0, 20));
            1:       s = lo_base + 33'd16 + 33'($urandom_range(0, 100));
            default: s = {1'b0, $urandom};
        endcase
        len = 11'($urandom_range(0, 2047));
        if (len == 0 && {1'b0, s[31:0]} >= lo_base && {1'b0, s[31:0]} < lo_base + 33'd16)
            len = 11'd1;
        add_pkt(s[31:0], len, rand_word());
    endfunction

    // One shuffled run of consecutive packets from the base, sometimes with a hole,
    // duplicates and noise mixed in; returns the number of packets queued
    function automatic int gen_burst();
        logic [32:0] win_lo;
        logic [32:0] lo_base;
        logic [32:0] s;
        logic [32:0] tmp;
        logic [32:0] run [$];
        int          k;
        int          hole;
        int          i;
        int          j;
        int          n;
        win_lo = gen_base;
        lo_base = (win_lo > {1'b0, srr_pkg::SeqMax}) ? {1'b0, srr_pkg::SeqMax} : win_lo;
        k = $urandom_range(1, WIN);
        hole = ($urandom_range(0, 9) == 0) ? $urandom_range(0, k - 1) : k;
        for (i = 0; i < k; i++)
            if (i != hole) run.push_back(win_lo + 33'(i));
        for (i = run.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = run[i];
            run[i] = run[j];
            run[j] = tmp;
        end
        gen_base = win_lo + 33'(hole);
        n = 0;
        foreach (run[m]) begin
            if ($urandom_range(0, 4) == 0) begin
                add_noise(lo_base);
                n++;
            end
            s = (run[m] > {1'b0, srr_pkg::SeqMax}) ? {1'b0, srr_pkg::SeqMax} : run[m];
            add_pkt(s[31:0], rand_len(), rand_word());
            n++;
            if ($urandom_range(0, 9) == 0) begin
                add_pkt(s[31:0], rand_len(), rand_word());
                n++;
            end
        end
        return n;
    endfunction

    task automatic wait_idle();
        while (pkt_q.size() != 0 || s_valid || rx_pending.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apb_write_initial_seq(logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrInitialSeq;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rx_base = value;
        gen_base = {1'b0, value};
    endtask

    task automatic run_phase(logic [31:0] init, int n_items);
        int n;
        wait_idle();
        apb_write_initial_seq(init);
        @(negedge aclk);
        n = 0;
        while (n < n_items) n += gen_burst();
    endtask

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Base 0 after reset: delivery, oversize length, duplicate, drain
        add_pkt(32'd0, 11'd1, '1);
        add_pkt(32'd3, 11'h7FF, '0);
        add_pkt(32'd3, 11'd5, rand_word());
        add_pkt(32'd2, 11'd1024, rand_word());
        add_pkt(32'd1, 11'd100, rand_word());
        add_pkt(32'd12, 11'd7, rand_word());        // one past the window
        add_pkt(32'd0, 11'd0, rand_word());         // below window, empty payload
        add_pkt(32'hFFFF_FFFF, 11'd0, rand_word());
        // fill the window behind the base, then the base drains all of it
        for (i = 11; i >= 5; i--) add_pkt(32'(i), rand_len(), rand_word());
        add_pkt(32'd4, 11'd1, rand_word());

        // Base saturation at the top of the sequence space
        wait_idle();
        apb_write_initial_seq(32'hFFFF_FFFA);
        @(negedge aclk);
        for (i = 5; i >= 1; i--) add_pkt(32'hFFFF_FFFA + 32'(i), rand_len(), rand_word());
        add_pkt(32'hFFFF_FFFA, rand_len(), rand_word());
        add_pkt(32'hFFFF_FFFF, rand_len(), rand_word());
        add_pkt(32'hFFFF_FFFE, rand_len(), rand_word());

        // Random phases across several base settings
        run_phase(32'hFFFF_FFFF, 30);
        run_phase(32'h0000_0000, 80);

        run_phase($urandom, 80);
        @(negedge aclk);
        hold_req = ~hold_req;                       // block backs up behind the stall

        wait_idle();
        @(negedge aclk);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(32'hFFFF_FFE0, 80);

        wait_idle();
        @(negedge aclk);
        src_idle_pct = 25;
        sink_idle_pct = 25;
        run_phase(32'h8000_0000, 80);

        // Last phase closes the stream mid-window with packets buffered
        run_phase(32'($urandom_range(0, 32'h7FFF_FFFF)), 60);
        add_pkt(gen_base[31:0] + 32'd1, rand_len(), rand_word());
        add_pkt(gen_base[31:0] + 32'd3, rand_len(), rand_word());
        add_pkt(gen_base[31:0] + 32'd5, 11'd0, rand_word());
        // closed stream: all of these are dropped silently
        add_pkt(gen_base[31:0], rand_len(), rand_word());
        add_pkt(gen_base[31:0] + 32'd2, 11'd0, rand_word());
        for (i = 0; i < 4; i++) add_pkt($urandom, 11'($urandom_range(0, 2047)), rand_word());

        wait_idle();
        if (err_cnt == 0 && rx_pending.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
